>>> rtl/core/i2cbm_pkg.sv
package i2cbm_pkg;

   // tick counter width, 4..32
   localparam int TICK_COUNTER_BITS = 16;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;
   localparam logic [4:0]  STEP_IDLE         = 5'd31;

   // command opcodes
   localparam logic [2:0] OP_START    = 3'd0;
   localparam logic [2:0] OP_STOP     = 3'd1;
   localparam logic [2:0] OP_WRITE    = 3'd2;
   localparam logic [2:0] OP_READ     = 3'd3;
   localparam logic [2:0] OP_SEND_ACK = 3'd4;
   localparam logic [2:0] OP_READ_ACK = 3'd5;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       ack_level;
      logic       sda_line;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } rsp_type;

   // classified tick as it sits in the queue
   typedef struct packed {
      logic       cmd_ok;
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       ack_level;
      logic       sda_line;
   } tick_type;

endpackage

>>> rtl/core/i2c_bit_level_master.sv
// Channel  Ports              Dir   Moves
// req      req_valid/ready    in    one tick item: command fields and sampled SDA
// rsp      rsp_valid/ready    out   one result item per tick: pins, busy, done, rx, ack
// csr      csr_wr_en/wr_data  in    phase_ticks write, taken on the enable edge
//
// One result item per tick item; a new tick item is taken every clock cycle while the queue is not full.
// Each item passes through the two-entry queue, then into the result register
// of the phase sequencer. The sequencer advances once per item.
// Reset (synchronous) returns to idle with both lines released, phase_ticks 10.
// Either side may stall; the queue and the result register hold items meanwhile.
module i2c_bit_level_master (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  i2cbm_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output i2cbm_pkg::rsp_type rsp_item,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);
   import i2cbm_pkg::*;

   // front to back queue
   logic     q_valid;
   logic     q_ready;
   tick_type q_item;

   // front: classifies each tick and queues it
   i2cbm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   // back: phase sequencer, shift registers, result register
   i2cbm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

endmodule

>>> rtl/core/i2cbm_front.sv
module i2cbm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cbm_pkg::req_type  req_item,
   output logic                q_valid,
   input  logic                q_ready,
   output i2cbm_pkg::tick_type q_item
);
   import i2cbm_pkg::*;

   tick_type   mem [2];
   tick_type   cls;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // classify: only a valid, known opcode counts as a command
   always_comb begin
      cls.cmd_ok    = req_item.cmd_valid && (req_item.opcode <= OP_READ_ACK);
      cls.opcode    = req_item.opcode;
      cls.tx_byte   = req_item.tx_byte;
      cls.ack_level = req_item.ack_level;
      cls.sda_line  = req_item.sda_line;
   end

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = mem[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/i2cbm_back.sv
module i2cbm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   input  logic                q_valid,
   output logic                q_ready,
   input  i2cbm_pkg::tick_type q_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cbm_pkg::rsp_type  rsp_item
);
   import i2cbm_pkg::*;

   localparam int CW = TICK_COUNTER_BITS;
   localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;

   typedef enum logic [2:0] {
      ACT_SDA_LOW,
      ACT_SDA_HIGH,
      ACT_SCL_LOW,
      ACT_SCL_HIGH,
      ACT_SAMPLE,
      ACT_END
   } act_type;

   logic [15:0]   phase_ticks_ff;
   logic [4:0]    step_ff, step_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [CW-1:0] tick_ff, tick_in;
   logic [3:0]    bit_ff, bit_in;
   logic [1:0]    sub_ff, sub_in;
   logic [7:0]    sout_ff, sout_in;
   logic [7:0]    sin_ff, sin_in;
   logic          ack_ff, ack_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   logic          pop;
   logic [32:0]   limit;
   logic [32:0]   pt_eff;
   logic          phase_over;
   logic [4:0]    s_new;
   logic [3:0]    nb_new;
   logic [1:0]    ns_new;
   logic          done;
   act_type       act;

   // action of phase s; nb/ns are bit number and position within the bit
   function automatic act_type phase_act(input logic [2:0] cmd, input logic [4:0] s,
                                         input logic [3:0] nb, input logic [1:0] ns,
                                         input logic [7:0] so);
      act_type a;
      logic    dbit;
      dbit = so[3'd7 - nb[2:0]];
      a    = ACT_END;
      case (cmd)
         OP_START: begin
            case (s)
               5'd0:    a = ACT_SDA_HIGH;
               5'd1:    a = ACT_SCL_HIGH;
               5'd2:    a = ACT_SDA_LOW;
               5'd3:    a = ACT_SCL_LOW;
               default: a = ACT_END;
            endcase
         end
         OP_STOP: begin
            case (s)
               5'd0:    a = ACT_SDA_LOW;
               5'd1:    a = ACT_SCL_HIGH;
               5'd2:    a = ACT_SDA_HIGH;
               default: a = ACT_END;
            endcase
         end
         OP_WRITE: begin
            if (nb[3]) begin
               a = ACT_END;
            end else if (ns == 2'd0) begin
               a = dbit ? ACT_SDA_HIGH : ACT_SDA_LOW;
            end else if (ns == 2'd1) begin
               a = ACT_SCL_HIGH;
            end else begin
               a = ACT_SCL_LOW;
            end
         end
         OP_READ: begin
            if (s == 5'd0) begin
               a = ACT_SDA_HIGH;
            end else if (nb[3]) begin
               a = ACT_END;
            end else if (ns == 2'd0) begin
               a = ACT_SCL_HIGH;
            end else if (ns == 2'd1) begin
               a = ACT_SAMPLE;
            end else begin
               a = ACT_SCL_LOW;
            end
         end
         OP_SEND_ACK: begin
            case (s)
               5'd0:    a = so[7] ? ACT_SDA_HIGH : ACT_SDA_LOW;
               5'd1:    a = ACT_SCL_HIGH;
               5'd2:    a = ACT_SCL_LOW;
               default: a = ACT_END;
            endcase
         end
         OP_READ_ACK: begin
            case (s)
               5'd0:    a = ACT_SDA_HIGH;
               5'd1:    a = ACT_SCL_HIGH;
               5'd2:    a = ACT_SAMPLE;
               5'd3:    a = ACT_SCL_LOW;
               default: a = ACT_END;
            endcase
         end
         default: a = ACT_END;
      endcase
      return a;
   endfunction

   assign q_ready   = !rsp_valid_ff || rsp_ready;
   assign pop       = q_valid && q_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // effective phase length: zero means one, saturate at counter range
   always_comb begin
      pt_eff     = (phase_ticks_ff == 16'd0) ? 33'd1 : {17'd0, phase_ticks_ff};
      limit      = (pt_eff > CNT_MAX) ? CNT_MAX : pt_eff;
      phase_over = (33'(tick_ff) >= limit);
   end

   always_comb begin
      step_in = step_ff;
      cmd_in  = cmd_ff;
      tick_in = tick_ff;
      bit_in  = bit_ff;
      sub_in  = sub_ff;
      sout_in = sout_ff;
      sin_in  = sin_ff;
      ack_in  = ack_ff;
      scl_in  = scl_ff;
      sda_in  = sda_ff;
      done    = 1'b0;
      s_new   = 5'd0;
      nb_new  = 4'd0;
      ns_new  = 2'd0;
      act     = ACT_END;

      if (step_ff == STEP_IDLE) begin
         if (q_item.cmd_ok) begin
            cmd_in = q_item.opcode;
            if (q_item.opcode == OP_WRITE) begin
               sout_in = q_item.tx_byte;
            end else if (q_item.opcode == OP_SEND_ACK) begin
               sout_in = {q_item.ack_level, 7'd0};
            end
            if (q_item.opcode == OP_READ) begin
               sin_in = 8'd0;
            end
            act = phase_act(cmd_in, 5'd0, 4'd0, 2'd0, sout_in);
         end
      end else if (phase_over) begin
         s_new = step_ff + 5'd1;
         if (cmd_ff == OP_READ && step_ff == 5'd0) begin
            nb_new = 4'd0;
            ns_new = 2'd0;
         end else if (sub_ff == 2'd2) begin
            nb_new = bit_ff + 4'd1;
            ns_new = 2'd0;
         end else begin
            nb_new = bit_ff;
            ns_new = sub_ff + 2'd1;
         end
         act = phase_act(cmd_ff, s_new, nb_new, ns_new, sout_ff);
         if (act == ACT_END) begin
            step_in = STEP_IDLE;
            tick_in = '0;
            done    = 1'b1;
         end
      end else begin
         tick_in = tick_ff + CW'(1);
      end

      // carry out the new phase's pin write or sample
      if (act != ACT_END) begin
         step_in = s_new;
         bit_in  = nb_new;
         sub_in  = ns_new;
         tick_in = CW'(1);
         case (act)
            ACT_SDA_LOW:  sda_in = 1'b0;
            ACT_SDA_HIGH: sda_in = 1'b1;
            ACT_SCL_LOW:  scl_in = 1'b0;
            ACT_SCL_HIGH: scl_in = 1'b1;
            ACT_SAMPLE: begin
               if (cmd_in == OP_READ) begin
                  if (q_item.sda_line) begin
                     sin_in[3'd7 - nb_new[2:0]] = 1'b1;
                  end
               end else begin
                  ack_in = q_item.sda_line;
               end
            end
            default: ;
         endcase
      end

      rsp_in.scl_out  = scl_in;
      rsp_in.sda_out  = sda_in;
      rsp_in.busy_res = (step_in != STEP_IDLE);
      rsp_in.done_res = done;
      rsp_in.rx_byte  = sin_in;
      rsp_in.ack_seen = ack_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         step_ff        <= STEP_IDLE;
         cmd_ff         <= OP_START;
         tick_ff        <= '0;
         bit_ff         <= 4'd0;
         sub_ff         <= 2'd0;
         sout_ff        <= 8'd0;
         sin_ff         <= 8'd0;
         ack_ff         <= 1'b1;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
         if (pop) begin
            step_ff <= step_in;
            cmd_ff  <= cmd_in;
            tick_ff <= tick_in;
            bit_ff  <= bit_in;
            sub_ff  <= sub_in;
            sout_ff <= sout_in;
            sin_ff  <= sin_in;
            ack_ff  <= ack_in;
            scl_ff  <= scl_in;
            sda_ff  <= sda_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
